/* rtl/ket_pkg.sv */
// Shared types and constants for the keyed entry table.
`default_nettype none

package ket_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int NAME_BITS_DEF = 64;
    localparam int ID_W          = 32;
    localparam int NAME_W        = 64;
    localparam int CAP_W         = 7;
    localparam int CNT_W         = 7;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;

    typedef enum logic [OP_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_UPDATE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_CLASH   = 3'd4
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic move;
        logic dec_count;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic need_move;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/ket_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ket_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/ket_ctrl.sv */
// Sequencing state machine for the keyed entry table.
`default_nettype none

module ket_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ket_pkg::t_dp_sts i_sts,
    output ket_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_SCAN;
                        r_in_ready <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= i_sts.need_move ? S_MOVE : S_FINISH;
                end
                S_MOVE: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.decide    = (r_state == S_DECIDE);
        o_cmd.move      = (r_state == S_MOVE);
        o_cmd.dec_count = (r_state == S_MOVE) && i_sts.scan_done;
        o_cmd.load_out  = (r_state == S_FINISH) && i_sts.out_free;
    end

    assign o_in_ready = r_in_ready;

endmodule

`default_nettype wire

/* rtl/ket_dp.sv */
// Datapath of the keyed entry table: entry RAM, scan compare, verdict and result register.
`default_nettype none

module ket_dp #(
    parameter int DEPTH     = ket_pkg::DEPTH_DEF,
    parameter int NAME_BITS = ket_pkg::NAME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ket_pkg::t_dp_cmd              i_cmd,
    output ket_pkg::t_dp_sts                   o_sts,
    input  wire logic                          i_cfg_valid,
    input  wire logic [ket_pkg::CAP_W-1:0]     i_cfg_data,
    input  wire logic [ket_pkg::OP_W-1:0]      i_op,
    input  wire logic [ket_pkg::ID_W-1:0]      i_key_id,
    input  wire logic [ket_pkg::ID_W-1:0]      i_new_id,
    input  wire logic [ket_pkg::NAME_W-1:0]    i_new_name,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [ket_pkg::STATUS_W-1:0]  o_status,
    output logic      [ket_pkg::NAME_W-1:0]    o_found_name,
    output logic      [ket_pkg::CNT_W-1:0]     o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ket_pkg::ID_W + NAME_BITS;
    localparam int LW = (CW > ket_pkg::CAP_W) ? CW : ket_pkg::CAP_W;

    // Table state and configuration
    logic [CW-1:0]               r_count;
    logic [ket_pkg::CAP_W-1:0]   r_cap;

    // Current item
    ket_pkg::t_op                r_op;
    logic [ket_pkg::ID_W-1:0]    r_key;
    logic [ket_pkg::ID_W-1:0]    r_nid;
    logic [NAME_BITS-1:0]        r_name;

    // Scan / move pipeline
    logic [CW-1:0]               r_addr;
    logic                        r_cmp_vld;
    logic [AW-1:0]               r_cmp_idx;
    logic [AW-1:0]               r_mv_idx;

    // Scan results
    logic                        r_key_hit;
    logic [AW-1:0]               r_key_pos;
    logic [NAME_BITS-1:0]        r_key_name;
    logic                        r_nid_any;
    logic                        r_nid_clash;

    // Latched verdict and output register
    ket_pkg::t_status            r_res_status;
    logic [NAME_BITS-1:0]        r_res_found;
    logic                        r_out_valid;
    ket_pkg::t_status            r_out_status;
    logic [NAME_BITS-1:0]        r_out_found;
    logic [ket_pkg::CNT_W-1:0]   r_out_count;

    logic                        rd_en;
    logic [WW-1:0]               rd_data;
    logic [ket_pkg::ID_W-1:0]    rd_id;
    logic [NAME_BITS-1:0]        rd_name;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [WW-1:0]               wr_data;

    logic [LW-1:0]               cap_ext;
    logic [LW-1:0]               depth_ext;
    logic [LW-1:0]               limit;
    logic                        full;

    ket_pkg::t_status            v_status;
    logic                        v_write;
    logic                        v_move;
    logic [NAME_BITS-1:0]        v_found;

    assign rd_en   = (i_cmd.scan || i_cmd.move) && (r_addr < r_count);
    assign rd_id   = rd_data[WW-1:NAME_BITS];
    assign rd_name = rd_data[NAME_BITS-1:0];

    assign cap_ext   = LW'(r_cap);
    assign depth_ext = LW'(DEPTH);
    assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
    assign full      = LW'(r_count) >= limit;

    always_comb begin
        v_status = ket_pkg::ST_OK;
        v_write  = 1'b0;
        v_move   = 1'b0;
        v_found  = '0;
        unique case (r_op)
            ket_pkg::CMD_ADD: begin
                if (full) begin
                    v_status = ket_pkg::ST_FULL;
                end else if (r_nid_any) begin
                    v_status = ket_pkg::ST_DUP;
                end else begin
                    v_write = 1'b1;
                end
            end
            ket_pkg::CMD_DELETE: begin
                if (r_key_hit) begin
                    v_move = 1'b1;
                end else begin
                    v_status = ket_pkg::ST_MISSING;
                end
            end
            ket_pkg::CMD_LOOKUP: begin
                if (r_key_hit) begin
                    v_found = r_key_name;
                end else begin
                    v_status = ket_pkg::ST_MISSING;
                end
            end
            ket_pkg::CMD_UPDATE: begin
                if (r_nid_clash) begin
                    v_status = ket_pkg::ST_CLASH;
                end else if (r_key_hit) begin
                    v_write = 1'b1;
                end else begin
                    v_status = ket_pkg::ST_MISSING;
                end
            end
            default: begin
                v_status = ket_pkg::ST_MISSING;
            end
        endcase
    end

    // Compaction writes win; they never overlap a decide cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_mv_idx;
        wr_data = rd_data;
        if (i_cmd.move && r_cmp_vld) begin
            wr_en = 1'b1;
        end else if (i_cmd.decide && v_write) begin
            wr_en   = 1'b1;
            wr_addr = (r_op == ket_pkg::CMD_ADD) ? r_count[AW-1:0] : r_key_pos;
            wr_data = {r_nid, r_name};
        end
    end

    ket_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= ket_pkg::CAP_W'(64);
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.decide && v_write && (r_op == ket_pkg::CMD_ADD)) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= ket_pkg::t_op'(i_op);
            r_key       <= i_key_id;
            r_nid       <= i_new_id;
            r_name      <= i_new_name[NAME_BITS-1:0];
            r_addr      <= '0;
            r_key_hit   <= 1'b0;
            r_nid_any   <= 1'b0;
            r_nid_clash <= 1'b0;
        end else begin
            if (rd_en) begin
                r_addr    <= r_addr + CW'(1);
                r_cmp_idx <= r_addr[AW-1:0];
            end
            if (i_cmd.scan && r_cmp_vld) begin
                if ((rd_id == r_key) && !r_key_hit) begin
                    r_key_hit  <= 1'b1;
                    r_key_pos  <= r_cmp_idx;
                    r_key_name <= rd_name;
                end
                if (rd_id == r_nid) begin
                    r_nid_any <= 1'b1;
                    // the key's own entry does not clash with itself
                    if (!((rd_id == r_key) && !r_key_hit)) begin
                        r_nid_clash <= 1'b1;
                    end
                end
            end
            if (i_cmd.decide) begin
                r_addr   <= CW'(r_key_pos) + CW'(1);
                r_mv_idx <= r_key_pos;
            end
        end
        if (i_cmd.move && r_cmp_vld) begin
            r_mv_idx <= r_mv_idx + AW'(1);
        end
        if (i_cmd.decide) begin
            r_res_status <= v_status;
            r_res_found  <= v_found;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_count  <= ket_pkg::CNT_W'(r_count);
        end
    end

    assign o_sts.scan_done = (r_addr >= r_count) && !r_cmp_vld;
    assign o_sts.need_move = v_move;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_name  = ket_pkg::NAME_W'(r_out_found);
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

/* rtl/keyed_entry_table_unit.sv */
// Top level of the keyed entry table: controller, datapath and stream ports.
//
// Items come in on the slave stream: s_axis_tuser carries the operation
// (add, delete, lookup, update), s_axis_tdata the key id, new id and name.
// Each item yields exactly one result transfer on the master stream:
// m_axis_tuser carries the status code, m_axis_tdata the found name and the
// entry count after the operation. The capacity register is written through
// the cfg channel (always ready); write it only while no item is in flight.
// One item at a time: every operation scans the held entries through the
// single read port of the entry RAM, one entry per cycle. The result becomes
// valid and ready returns in the same cycle, so the next item is taken only
// after the result of the last one is in the output register.
// A delete adds a compaction pass that moves each later entry up one slot.
// Reset is synchronous, active low: the table empties and capacity returns to
// 64. The RAM itself is not cleared; only written slots are ever read.
// A result waits in the output register while the master side stalls; the
// block still scans the next item and holds in its final step until the
// output register frees.
`default_nettype none

module keyed_entry_table_unit #(
    parameter int DEPTH     = ket_pkg::DEPTH_DEF,
    parameter int NAME_BITS = ket_pkg::NAME_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel: capacity
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [6:0]   i_cfg_data,
    // command stream in
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // key_id[31:0], new_id[63:32], new_name[127:64]
    input  wire logic [1:0]   s_axis_tuser,  // cmd[1:0]
    // result stream out
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,  // found_name[63:0], entry_count[70:64], zero[71]
    output logic [2:0]        m_axis_tuser   // status[2:0]
);

    ket_pkg::t_dp_cmd dp_cmd;
    ket_pkg::t_dp_sts dp_sts;

    logic [ket_pkg::NAME_W-1:0] found_name;
    logic [ket_pkg::CNT_W-1:0]  entry_count;

    assign o_cfg_ready = 1'b1;

    // Sequence the scan, decision, compaction and result steps
    ket_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Hold the entries and compute each verdict
    ket_dp #(
        .DEPTH     (DEPTH),
        .NAME_BITS (NAME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_key_id      (s_axis_tdata[31:0]),
        .i_new_id      (s_axis_tdata[63:32]),
        .i_new_name    (s_axis_tdata[127:64]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_found_name  (found_name),
        .o_entry_count (entry_count)
    );

    assign m_axis_tdata = {1'b0, entry_count, found_name};

    // A nonzero name is returned only by a successful lookup
    a_name_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[63:0] != 64'd0))
            |-> (m_axis_tuser == 3'(ket_pkg::ST_OK)))
        else $error("nonzero found_name with failing status");

    // No result can appear in the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared one cycle after acceptance");

    // The block takes no new item while a result for it would still be pending scan
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a transfer");

endmodule

`default_nettype wire
